>>> hdl/swsplit_pkg.sv
// Package for the shell word splitter: parse modes, character codes,
// result beat type and helper functions. No dependencies.
package swsplit_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int OUT_COUNT_BITS = 16;

    typedef enum logic [2:0]
    {
        MODE_IDLE     = 3'd0,
        MODE_WORD     = 3'd1,
        MODE_WESC     = 3'd2,
        MODE_RAW      = 3'd3,
        MODE_RAWESC   = 3'd4,
        MODE_COOK     = 3'd5,
        MODE_COOKESC  = 3'd6
    } mode_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF_CH = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LV    = 8'h76;

    typedef struct packed
    {
        logic [7:0]                  out_byte;
        logic                        byte_valid;
        logic                        word_end;
        logic                        string_end;
        logic                        status;
        logic [OUT_COUNT_BITS-1:0]   word_count;
        logic                        last;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] cook(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LA:    r = CH_BEL;
            CH_LB:    r = CH_BS;
            CH_LT:    r = CH_TAB;
            CH_LN:    r = CH_LF;
            CH_LV:    r = CH_VT;
            CH_LF_CH: r = CH_FF;
            CH_LR:    r = CH_CR;
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/swsplit_parser.sv
// Input register, parse mode and word counter of the shell word splitter.
// Emits at most one result beat per cycle. Depends on swsplit_pkg.
module swsplit_parser #(
    parameter int COUNT_BITS = swsplit_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    input  logic                 res_ready,
    output swsplit_pkg::result_t res
);

    logic                    byte_valid_reg;
    logic [7:0]              byte_reg;
    swsplit_pkg::mode_t      mode_reg, mode_next;
    logic                    half_reg, half_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    logic                    fire, consume, split_first, bump;
    logic                    is_nul, is_sp, is_bs, is_bsl, is_sq, is_dq;
    logic [COUNT_BITS-1:0]   count_eff;
    logic [COUNT_BITS+15:0]  count_wide;
    logic                    has_res;
    logic [7:0]              r_byte;
    logic                    r_bv, r_we, r_se, r_st, r_last;

    assign is_nul = (byte_reg == swsplit_pkg::CH_NUL);
    assign is_sp  = swsplit_pkg::is_space(byte_reg);
    assign is_bs  = (byte_reg == swsplit_pkg::CH_BS);
    assign is_bsl = (byte_reg == swsplit_pkg::CH_BSLASH);
    assign is_sq  = (byte_reg == swsplit_pkg::CH_SQUOTE);
    assign is_dq  = (byte_reg == swsplit_pkg::CH_DQUOTE);

    assign fire        = byte_valid_reg && res_ready;
    assign split_first = (mode_reg == swsplit_pkg::MODE_RAWESC) && !is_nul &&
                         !is_bsl && !is_sq && !half_reg;
    assign consume     = fire && !split_first;
    assign in_stall    = byte_valid_reg && !consume;

    assign bump      = (mode_reg == swsplit_pkg::MODE_IDLE) && !is_nul && !is_sp;
    assign count_eff = (bump && (count_reg != {COUNT_BITS{1'b1}})) ?
                       count_reg + COUNT_BITS'(1) : count_reg;
    assign count_wide = {16'd0, count_eff};

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg) inside
            swsplit_pkg::MODE_IDLE, swsplit_pkg::MODE_WORD:
            begin
                if (is_nul || is_sp || is_bs)
                    mode_next = swsplit_pkg::MODE_IDLE;
                else if (is_bsl)
                    mode_next = swsplit_pkg::MODE_WESC;
                else if (is_sq)
                    mode_next = swsplit_pkg::MODE_RAW;
                else if (is_dq)
                    mode_next = swsplit_pkg::MODE_COOK;
                else
                    mode_next = swsplit_pkg::MODE_WORD;
            end
            swsplit_pkg::MODE_WESC:
                mode_next = is_nul ? swsplit_pkg::MODE_IDLE : swsplit_pkg::MODE_WORD;
            swsplit_pkg::MODE_RAW:
            begin
                if (is_nul)
                    mode_next = swsplit_pkg::MODE_IDLE;
                else if (is_sq)
                    mode_next = swsplit_pkg::MODE_WORD;
                else if (is_bsl)
                    mode_next = swsplit_pkg::MODE_RAWESC;
            end
            swsplit_pkg::MODE_COOK:
            begin
                if (is_nul)
                    mode_next = swsplit_pkg::MODE_IDLE;
                else if (is_dq)
                    mode_next = swsplit_pkg::MODE_WORD;
                else if (is_bsl)
                    mode_next = swsplit_pkg::MODE_COOKESC;
            end
            swsplit_pkg::MODE_RAWESC:
            begin
                if (is_nul)
                    mode_next = swsplit_pkg::MODE_IDLE;
                else if (!split_first)
                    mode_next = swsplit_pkg::MODE_RAW;
            end
            swsplit_pkg::MODE_COOKESC:
                mode_next = is_nul ? swsplit_pkg::MODE_IDLE : swsplit_pkg::MODE_COOK;
            default:
                mode_next = swsplit_pkg::MODE_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        has_res = 1'b0;
        r_byte  = byte_reg;
        r_bv    = 1'b0;
        r_we    = 1'b0;
        r_se    = 1'b0;
        r_st    = 1'b0;
        r_last  = 1'b1;
        unique case (mode_reg)
            swsplit_pkg::MODE_IDLE:
            begin
                if (is_nul)
                begin
                    has_res = 1'b1;
                    r_se    = 1'b1;
                end
                else if (is_bs)
                begin
                    has_res = 1'b1;
                    r_we    = 1'b1;
                end
                else if (!is_sp && !is_bsl && !is_sq && !is_dq)
                begin
                    has_res = 1'b1;
                    r_bv    = 1'b1;
                end
            end
            swsplit_pkg::MODE_WORD:
            begin
                if (is_nul)
                begin
                    has_res = 1'b1;
                    r_we    = 1'b1;
                    r_se    = 1'b1;
                end
                else if (is_sp || is_bs)
                begin
                    has_res = 1'b1;
                    r_we    = 1'b1;
                end
                else if (!is_bsl && !is_sq && !is_dq)
                begin
                    has_res = 1'b1;
                    r_bv    = 1'b1;
                end
            end
            swsplit_pkg::MODE_WESC:
            begin
                has_res = 1'b1;
                r_we    = is_nul;
                r_se    = is_nul;
                r_bv    = !is_nul;
            end
            swsplit_pkg::MODE_RAW:
            begin
                if (is_nul)
                begin
                    has_res = 1'b1;
                    r_se    = 1'b1;
                    r_st    = 1'b1;
                end
                else if (!is_sq && !is_bsl)
                begin
                    has_res = 1'b1;
                    r_bv    = 1'b1;
                end
            end
            swsplit_pkg::MODE_COOK:
            begin
                if (is_nul)
                begin
                    has_res = 1'b1;
                    r_se    = 1'b1;
                    r_st    = 1'b1;
                end
                else if (!is_dq && !is_bsl)
                begin
                    has_res = 1'b1;
                    r_bv    = 1'b1;
                end
            end
            swsplit_pkg::MODE_RAWESC:
            begin
                has_res = 1'b1;
                if (is_nul)
                begin
                    r_se = 1'b1;
                    r_st = 1'b1;
                end
                else if (split_first)
                begin
                    r_bv   = 1'b1;
                    r_byte = swsplit_pkg::CH_BSLASH;
                    r_last = 1'b0;
                end
                else
                    r_bv = 1'b1;
            end
            swsplit_pkg::MODE_COOKESC:
            begin
                has_res = 1'b1;
                if (is_nul)
                begin
                    r_se = 1'b1;
                    r_st = 1'b1;
                end
                else
                begin
                    r_bv   = 1'b1;
                    r_byte = swsplit_pkg::cook(byte_reg);
                end
            end
            default:
                has_res = 1'b0;
        endcase
    end

    assign res_valid      = fire && has_res;
    assign res.out_byte   = r_bv ? r_byte : 8'd0;
    assign res.byte_valid = r_bv;
    assign res.word_end   = r_we;
    assign res.string_end = r_se;
    assign res.status     = r_st;
    assign res.word_count = (|count_wide[COUNT_BITS+15:16]) ? 16'hFFFF : count_wide[15:0];
    assign res.last       = r_last;

    assign half_next  = fire ? split_first : half_reg;
    assign count_next = !consume ? count_reg :
                        (is_nul ? '0 : count_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            mode_reg       <= swsplit_pkg::MODE_IDLE;
            half_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (!byte_valid_reg || consume)
                byte_valid_reg <= in_valid;
            if (fire)
                mode_reg <= mode_next;
            half_reg  <= half_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_valid_reg || consume)
            byte_reg <= in_byte;
    end

endmodule

>>> hdl/swsplit_skid.sv
// Output register with one skid entry for result beats.
// Depends on swsplit_pkg.
module swsplit_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  swsplit_pkg::result_t up_data,
    output logic                 dn_valid,
    input  logic                 dn_stall,
    output swsplit_pkg::result_t dn_data
);

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    swsplit_pkg::result_t out_reg;
    swsplit_pkg::result_t skid_reg;
    logic                 advance;

    assign up_ready = !skid_valid_reg;
    assign advance  = !out_valid_reg || !dn_stall;
    assign dn_valid = out_valid_reg;
    assign dn_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg  <= skid_valid_reg || up_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (up_valid && up_ready)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= skid_valid_reg ? skid_reg : up_data;
        else if (up_valid && up_ready)
            skid_reg <= up_data;
    end

endmodule

>>> hdl/shell_word_splitter.sv
// Top level of the shell word splitter: parser plus output skid stage.
// Depends on swsplit_pkg, swsplit_parser, swsplit_skid.
//
//   channel   direction   handshake              payload
//   in        sink        in_valid / in_stall    in_byte
//   out       source      out_valid / out_stall  out_byte .. last
//
// One byte per cycle unless stalled, via the parser input register and
// then the skid output register. A backslash pair in single quotes copied
// as two bytes stalls input, since the parser emits one result per cycle.
// Reset returns the parser to idle between words with a zero word count.
// Output stall backs up through the skid entry into in_stall.
module shell_word_splitter #(
    parameter int COUNT_BITS = swsplit_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        word_end,
    output logic        string_end,
    output logic        status,
    output logic [15:0] word_count,
    output logic        last
);

    logic                 res_valid;
    logic                 res_ready;
    swsplit_pkg::result_t res;
    swsplit_pkg::result_t dn;

    swsplit_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    swsplit_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (res_valid),
        .up_ready (res_ready),
        .up_data  (res),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (dn)
    );

    assign out_byte   = dn.out_byte;
    assign byte_valid = dn.byte_valid;
    assign word_end   = dn.word_end;
    assign string_end = dn.string_end;
    assign status     = dn.status;
    assign word_count = dn.word_count;
    assign last       = dn.last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for shell_word_splitter: predicts every result beat from the
// byte stream and checks it against the output channel. Depends on swsplit_pkg.
module testbench;

    localparam int STUCK_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        word_end;
    logic        string_end;
    logic        status;
    logic [15:0] word_count;
    logic        last;

    // predictor state
    swsplit_pkg::mode_t                     split_mode = swsplit_pkg::MODE_IDLE;
    logic [swsplit_pkg::COUNT_BITS_DEF-1:0] words_open = '0;
    swsplit_pkg::result_t                   token_beats[$];

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int mismatches = 0;
    int stuck_cycles = 0;

    shell_word_splitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .word_end   (word_end),
        .string_end (string_end),
        .status     (status),
        .word_count (word_count),
        .last       (last)
    );

    always #1 clk = ~clk;

    function automatic logic is_ws(input logic [7:0] c);
        return c == swsplit_pkg::CH_SPACE || c == swsplit_pkg::CH_TAB ||
               c == swsplit_pkg::CH_LF || c == swsplit_pkg::CH_VT ||
               c == swsplit_pkg::CH_FF || c == swsplit_pkg::CH_CR;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            swsplit_pkg::CH_LA:    return swsplit_pkg::CH_BEL;
            swsplit_pkg::CH_LB:    return swsplit_pkg::CH_BS;
            swsplit_pkg::CH_LT:    return swsplit_pkg::CH_TAB;
            swsplit_pkg::CH_LN:    return swsplit_pkg::CH_LF;
            swsplit_pkg::CH_LV:    return swsplit_pkg::CH_VT;
            swsplit_pkg::CH_LF_CH: return swsplit_pkg::CH_FF;
            swsplit_pkg::CH_LR:    return swsplit_pkg::CH_CR;
            default:               return c;
        endcase
    endfunction

    function automatic void emit(input logic [7:0] b, input logic bv, input logic we,
                                 input logic se, input logic st);
        swsplit_pkg::result_t r;
        r.out_byte   = bv ? b : 8'h00;
        r.byte_valid = bv;
        r.word_end   = we;
        r.string_end = se;
        r.status     = se ? st : 1'b0;
        r.word_count = (longint'(words_open) > 65535) ? 16'hFFFF : 16'(words_open);
        r.last       = 1'b0;
        token_beats.push_back(r);
    endfunction

    function automatic void end_string();
        split_mode = swsplit_pkg::MODE_IDLE;
        words_open = '0;
    endfunction

    function automatic void word_char(input logic [7:0] c);
        if (c == swsplit_pkg::CH_NUL)
        begin
            emit(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            end_string();
        end
        else if (is_ws(c) || c == swsplit_pkg::CH_BS)
        begin
            emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            split_mode = swsplit_pkg::MODE_IDLE;
        end
        else if (c == swsplit_pkg::CH_BSLASH)
            split_mode = swsplit_pkg::MODE_WESC;
        else if (c == swsplit_pkg::CH_SQUOTE)
            split_mode = swsplit_pkg::MODE_RAW;
        else if (c == swsplit_pkg::CH_DQUOTE)
            split_mode = swsplit_pkg::MODE_COOK;
        else
            emit(c, 1'b1, 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c);
        int                   n0;
        swsplit_pkg::result_t tail;
        n0 = token_beats.size();
        case (split_mode) inside
            swsplit_pkg::MODE_IDLE:
            begin
                if (c == swsplit_pkg::CH_NUL)
                begin
                    emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
                    end_string();
                end
                else if (is_ws(c))
                    ;
                else
                begin
                    if (words_open != '1)
                        words_open++;
                    if (c == swsplit_pkg::CH_BS)
                        emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    else
                    begin
                        split_mode = swsplit_pkg::MODE_WORD;
                        word_char(c);
                    end
                end
            end
            swsplit_pkg::MODE_WORD:
                word_char(c);
            swsplit_pkg::MODE_WESC:
            begin
                if (c == swsplit_pkg::CH_NUL)
                begin
                    emit(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                    end_string();
                end
                else
                begin
                    emit(c, 1'b1, 1'b0, 1'b0, 1'b0);
                    split_mode = swsplit_pkg::MODE_WORD;
                end
            end
            swsplit_pkg::MODE_RAW, swsplit_pkg::MODE_COOK:
            begin
                if (c == swsplit_pkg::CH_NUL)
                begin
                    emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
                    end_string();
                end
                else if (split_mode == swsplit_pkg::MODE_RAW && c == swsplit_pkg::CH_SQUOTE)
                    split_mode = swsplit_pkg::MODE_WORD;
                else if (split_mode == swsplit_pkg::MODE_COOK && c == swsplit_pkg::CH_DQUOTE)
                    split_mode = swsplit_pkg::MODE_WORD;
                else if (c == swsplit_pkg::CH_BSLASH)
                    split_mode = (split_mode == swsplit_pkg::MODE_RAW) ?
                                 swsplit_pkg::MODE_RAWESC : swsplit_pkg::MODE_COOKESC;
                else
                    emit(c, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            swsplit_pkg::MODE_RAWESC:
            begin
                if (c == swsplit_pkg::CH_NUL)
                begin
                    emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
                    end_string();
                end
                else
                begin
                    if (c != swsplit_pkg::CH_BSLASH && c != swsplit_pkg::CH_SQUOTE)
                        emit(swsplit_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0);
                    emit(c, 1'b1, 1'b0, 1'b0, 1'b0);
                    split_mode = swsplit_pkg::MODE_RAW;
                end
            end
            swsplit_pkg::MODE_COOKESC:
            begin
                if (c == swsplit_pkg::CH_NUL)
                begin
                    emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
                    end_string();
                end
                else
                begin
                    emit(unescape(c), 1'b1, 1'b0, 1'b0, 1'b0);
                    split_mode = swsplit_pkg::MODE_COOK;
                end
            end
            default:
                split_mode = swsplit_pkg::MODE_IDLE;
        endcase
        if (token_beats.size() > n0)
        begin
            tail = token_beats.pop_back();
            tail.last = 1'b1;
            token_beats.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h (beat %0d, t=%0t)",
                 what, got, want, beats_checked, $realtime);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        swsplit_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_beats.size() == 0)
                report_mismatch("beat with nothing pending", out_byte, 0);
            else
            begin
                want = token_beats.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_byte, want.out_byte);
                if (byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", byte_valid, want.byte_valid);
                if (word_end !== want.word_end)
                    report_mismatch("word_end", word_end, want.word_end);
                if (string_end !== want.string_end)
                    report_mismatch("string_end", string_end, want.string_end);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (word_count !== want.word_count)
                    report_mismatch("word_count", word_count, want.word_count);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
            beats_checked++;
        end
    end

    // receiver stall, with a counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d beats pending",
                     STUCK_LIMIT, token_beats.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 99) < in_idle_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_byte <= 8'($urandom);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tokenize_byte(b);
        bytes_sent++;
    endtask

    task automatic go_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(input logic [7:0] ban0, input logic [7:0] ban1,
                                             input logic plain);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == ban0 || c == ban1 ||
               (plain && (is_ws(c) || c == swsplit_pkg::CH_BS ||
                          c == swsplit_pkg::CH_SQUOTE || c == swsplit_pkg::CH_DQUOTE)))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_gap_char();
        logic [7:0] sep[6];
        sep = '{swsplit_pkg::CH_SPACE, swsplit_pkg::CH_TAB, swsplit_pkg::CH_LF,
                swsplit_pkg::CH_VT, swsplit_pkg::CH_FF, swsplit_pkg::CH_CR};
        return ($urandom_range(0, 9) == 0) ? swsplit_pkg::CH_BS : sep[$urandom_range(0, 5)];
    endfunction

    task automatic send_word();
        logic [7:0] esc_letters[8];
        int         nseg;
        int         kind;
        esc_letters = '{swsplit_pkg::CH_LA, swsplit_pkg::CH_LB, swsplit_pkg::CH_LT,
                        swsplit_pkg::CH_LN, swsplit_pkg::CH_LV, swsplit_pkg::CH_LF_CH,
                        swsplit_pkg::CH_LR, swsplit_pkg::CH_BSLASH};
        nseg = $urandom_range(1, 4);
        repeat (nseg)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
                repeat ($urandom_range(1, 4))
                    send_byte(pick_byte(swsplit_pkg::CH_BSLASH, swsplit_pkg::CH_NUL, 1'b1));
            else if (kind == 4)
            begin
                send_byte(swsplit_pkg::CH_BSLASH);
                send_byte(8'($urandom_range(1, 255)));
            end
            else if (kind <= 6)
            begin
                send_byte(swsplit_pkg::CH_SQUOTE);
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(0, 9) < 7)
                        send_byte(pick_byte(swsplit_pkg::CH_SQUOTE,
                                            swsplit_pkg::CH_BSLASH, 1'b0));
                    else
                    begin
                        send_byte(swsplit_pkg::CH_BSLASH);
                        case ($urandom_range(0, 2))
                            0:       send_byte(swsplit_pkg::CH_BSLASH);
                            1:       send_byte(swsplit_pkg::CH_SQUOTE);
                            default: send_byte(8'($urandom_range(1, 255)));
                        endcase
                    end
                end
                send_byte(swsplit_pkg::CH_SQUOTE);
            end
            else
            begin
                send_byte(swsplit_pkg::CH_DQUOTE);
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(0, 9) < 6)
                        send_byte(pick_byte(swsplit_pkg::CH_DQUOTE,
                                            swsplit_pkg::CH_BSLASH, 1'b0));
                    else
                    begin
                        send_byte(swsplit_pkg::CH_BSLASH);
                        if ($urandom_range(0, 3) == 0)
                            send_byte(8'($urandom_range(1, 255)));
                        else
                            send_byte(esc_letters[$urandom_range(0, 7)]);
                    end
                end
                send_byte(swsplit_pkg::CH_DQUOTE);
            end
        end
    endtask

    // one command line: mostly well formed, some noise, some left open at the end
    task automatic send_line();
        int nwords;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            repeat ($urandom_range(3, 12))
                send_byte(($urandom_range(0, 7) == 0) ?
                          swsplit_pkg::CH_NUL : 8'($urandom_range(0, 255)));
            return;
        end
        nwords = $urandom_range(0, 5);
        if ($urandom_range(0, 1))
            send_byte(pick_gap_char());
        for (int w = 0; w < nwords; w++)
        begin
            send_word();
            if (w < nwords - 1 || $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(pick_gap_char());
        end
        if (roll >= 85)
        begin
            case ($urandom_range(0, 4))
                0: send_byte(swsplit_pkg::CH_SQUOTE);
                1: send_byte(swsplit_pkg::CH_DQUOTE);
                2:
                begin
                    send_byte(swsplit_pkg::CH_SQUOTE);
                    send_byte(swsplit_pkg::CH_BSLASH);
                end
                3:
                begin
                    send_byte(swsplit_pkg::CH_DQUOTE);
                    send_byte(swsplit_pkg::CH_BSLASH);
                end
                default: send_byte(swsplit_pkg::CH_BSLASH);
            endcase
        end
        send_byte(swsplit_pkg::CH_NUL);
    endtask

    task automatic send_lines(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_line();
    endtask

    task automatic wait_drained();
        go_quiet();
        while (token_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{swsplit_pkg::CH_SPACE, swsplit_pkg::CH_TAB, swsplit_pkg::CH_LF,
                swsplit_pkg::CH_VT, swsplit_pkg::CH_FF, swsplit_pkg::CH_CR,
                swsplit_pkg::CH_BS, 8'h78, swsplit_pkg::CH_BS, 8'hFF,
                swsplit_pkg::CH_BSLASH, 8'h01, swsplit_pkg::CH_SQUOTE,
                swsplit_pkg::CH_BSLASH, swsplit_pkg::CH_BSLASH, swsplit_pkg::CH_BSLASH,
                swsplit_pkg::CH_SQUOTE, swsplit_pkg::CH_BSLASH, 8'h71,
                swsplit_pkg::CH_SQUOTE, swsplit_pkg::CH_DQUOTE, swsplit_pkg::CH_BSLASH,
                swsplit_pkg::CH_LN, swsplit_pkg::CH_BSLASH, 8'h7A,
                swsplit_pkg::CH_DQUOTE, swsplit_pkg::CH_NUL,
                swsplit_pkg::CH_BSLASH, swsplit_pkg::CH_NUL,
                swsplit_pkg::CH_DQUOTE, swsplit_pkg::CH_NUL,
                swsplit_pkg::CH_SQUOTE, swsplit_pkg::CH_BSLASH, swsplit_pkg::CH_NUL,
                swsplit_pkg::CH_NUL};
        in_idle_pct = 0;
        out_stall_pct = 0;
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_long_line();
        in_idle_pct = 0;
        out_stall_pct = 0;
        send_byte(swsplit_pkg::CH_NUL);
        repeat (100)
            send_byte(swsplit_pkg::CH_BS);
        send_byte(swsplit_pkg::CH_NUL);
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
        in_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        send_lines(n);
    endtask

    task automatic test_output_hold();
        in_idle_pct = 0;
        out_stall_pct = 18;
        hold_left = 400;
        send_lines(120);
    endtask

    task automatic test_drain_pause();
        in_idle_pct = 18;
        out_stall_pct = 18;
        send_lines(50);
        wait_drained();
        send_lines(50);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_long_line();
        test_random_phase(250, 0, 0);
        test_random_phase(200, 67, 0);
        test_random_phase(200, 0, 67);
        test_random_phase(200, 18, 18);
        test_output_hold();
        test_drain_pause();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes and checked %0d result beats over directed, long-line,",
                 bytes_sent, beats_checked);
        $display("random, idle/stall, output-hold and drain phases; %0d mismatching fields",
                 mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
